/* rtl/u8u16sw_pkg.sv */
// Package: shared widths, register indexes, reset values, surrogate constants and the result record type.
`default_nettype none

package u8u16sw_pkg;

    localparam int unsigned TEXT_BYTE_W   = 8;
    localparam int unsigned CODE_UNIT_W   = 16;
    localparam int unsigned BYTE_ADDR_W   = 13;
    localparam int unsigned CFG_W         = 12;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CODE_POINT_W  = 21;
    localparam int unsigned PENDING_W     = 2;
    localparam int unsigned RESULT_SLOTS  = 3;
    localparam int unsigned RESULT_CNT_W  = 2;

    localparam int unsigned MAX_SLOT_BYTES_DEFAULT = 2048;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_BASE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_BYTES = 1'b1;

    localparam logic [CFG_W-1:0] SLOT_BASE_RESET  = 12'd0;
    localparam logic [CFG_W-1:0] SLOT_BYTES_RESET = 12'd64;

    // UTF-16 surrogate constants
    localparam logic [CODE_POINT_W-1:0] SUPP_OFFSET   = 21'h10000;
    localparam logic [CODE_UNIT_W-1:0]  HIGH_SURR_BASE = 16'hd800;
    localparam logic [CODE_UNIT_W-1:0]  LOW_SURR_BASE  = 16'hdc00;

    typedef struct packed {
        logic [CODE_UNIT_W-1:0] code_unit;
        logic [BYTE_ADDR_W-1:0] byte_address;
        logic                   is_terminator;
        logic                   last_of_run;
    } result_t;

endpackage

`default_nettype wire

/* rtl/u8u16sw_in_if.sv */
// Interface: input byte channel with valid/ready handshake.
`default_nettype none

interface u8u16sw_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [u8u16sw_pkg::TEXT_BYTE_W-1:0]   text_byte;
    logic                                  end_of_string;

    modport source (output valid, output text_byte, output end_of_string, input ready);
    modport sink   (input valid, input text_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

/* rtl/u8u16sw_out_if.sv */
// Interface: output code unit channel with valid/ready handshake.
`default_nettype none

interface u8u16sw_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [u8u16sw_pkg::CODE_UNIT_W-1:0]   code_unit;
    logic [u8u16sw_pkg::BYTE_ADDR_W-1:0]   byte_address;
    logic                                  is_terminator;
    logic                                  last_of_run;

    modport source (output valid, output code_unit, output byte_address,
                    output is_terminator, output last_of_run, input ready);
    modport sink   (input valid, input code_unit, input byte_address,
                    input is_terminator, input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/utf8_to_utf16_slot_writer_top.sv */
// Top level: UTF-8 byte stream to UTF-16LE slot writer with result buffer.
//
// Usage: UTF-8 bytes arrive on text_in, one byte per transaction, with
// end_of_string marking the last byte of a string. Each byte produces zero to
// three transactions on unit_out: a code unit, a surrogate pair, and/or the
// terminator item on the last byte. last_of_run flags the final result of a
// byte. slot_base and slot_bytes are to be written through cfg_we/cfg_index/cfg_data
// by the user only while the block is idle; the block itself does not enforce this.
// Latency: a byte's first result is valid the cycle after its acceptance.
// Throughput: one byte per cycle while each byte yields at most one result and
// unit_out is ready; a byte yielding k results holds the three-entry result
// buffer until all have left, and the next byte is taken in the cycle the last leaves.
// Reset: all decode state and the buffer count clear, slot_base reads 0 and
// slot_bytes reads 64.
// Stall: when unit_out is not ready the buffered results hold and text_in
// drops ready as long as any result is waiting; with one result left, the
// next byte is taken in the same cycle that result leaves.
`default_nettype none

module utf8_to_utf16_slot_writer_top #(
    parameter int unsigned MAX_SLOT_BYTES = u8u16sw_pkg::MAX_SLOT_BYTES_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [u8u16sw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [u8u16sw_pkg::CFG_W-1:0]       cfg_data,
    u8u16sw_in_if.sink                               text_in,
    u8u16sw_out_if.source                            unit_out
);

    localparam int unsigned UW   = $clog2(MAX_SLOT_BYTES) - 1;
    localparam int unsigned CW0  = $clog2(MAX_SLOT_BYTES) + 2;
    localparam int unsigned CW   = (CW0 > u8u16sw_pkg::CFG_W + 1) ? CW0
                                                                  : u8u16sw_pkg::CFG_W + 1;
    localparam int unsigned AW0  = UW + 2;
    localparam int unsigned AW   = (AW0 > u8u16sw_pkg::BYTE_ADDR_W) ? AW0
                                                                    : u8u16sw_pkg::BYTE_ADDR_W;
    localparam int unsigned PW   = u8u16sw_pkg::PENDING_W;
    localparam int unsigned CPW  = u8u16sw_pkg::CODE_POINT_W;
    localparam int unsigned NW   = u8u16sw_pkg::RESULT_CNT_W;

    // Configuration registers
    logic [u8u16sw_pkg::CFG_W-1:0] slot_base_reg;
    logic [u8u16sw_pkg::CFG_W-1:0] slot_bytes_reg;

    // Decode state
    logic [PW-1:0]  pending_reg,  pending_next;
    logic [CPW-1:0] acc_reg,      acc_next;
    logic [UW-1:0]  units_reg,    units_next;
    logic           full_reg,     full_next;

    // Result buffer
    u8u16sw_pkg::result_t res_reg [u8u16sw_pkg::RESULT_SLOTS];
    u8u16sw_pkg::result_t res_new [u8u16sw_pkg::RESULT_SLOTS];
    logic [NW-1:0]        cnt_reg;
    logic [NW-1:0]        n_new;

    logic                  in_fire;
    logic                  out_fire;
    logic [7:0]            b;
    logic                  have_cp;
    logic [CPW-1:0]        cp;
    logic [CPW-1:0]        acc_shift;
    logic [PW-1:0]         pend_dec;
    logic [CPW-1:0]        supp_v;
    logic [CW-1:0]         size_c;
    logic [CW-1:0]         used;
    logic                  fits_one;
    logic                  fits_two;
    logic                  is_pair;
    logic [UW:0]           units_p1;
    logic [UW:0]           units_p2;
    logic [u8u16sw_pkg::BYTE_ADDR_W-1:0] addr0, addr1, addr2;

    function automatic logic [u8u16sw_pkg::BYTE_ADDR_W-1:0] unit_addr(
        input logic [u8u16sw_pkg::CFG_W-1:0] base,
        input logic [UW:0]                   idx
    );
        logic [AW-1:0] sum;
        sum = AW'(base) + AW'({idx, 1'b0});
        return sum[u8u16sw_pkg::BYTE_ADDR_W-1:0];
    endfunction

    // Handshakes
    assign in_fire        = text_in.valid && text_in.ready;
    assign out_fire       = unit_out.valid && unit_out.ready;
    assign text_in.ready  = (cnt_reg == NW'(0)) || ((cnt_reg == NW'(1)) && unit_out.ready);
    assign unit_out.valid = (cnt_reg != NW'(0));
    assign unit_out.code_unit     = res_reg[0].code_unit;
    assign unit_out.byte_address  = res_reg[0].byte_address;
    assign unit_out.is_terminator = res_reg[0].is_terminator;
    assign unit_out.last_of_run   = res_reg[0].last_of_run;

    // Decode one UTF-8 byte
    assign b         = text_in.text_byte;
    assign acc_shift = {acc_reg[CPW-7:0], b[5:0]};
    assign pend_dec  = pending_reg - PW'(1);

    always_comb
    begin
        have_cp      = 1'b0;
        cp           = '0;
        pending_next = pending_reg;
        acc_next     = acc_reg;
        if (!full_reg)
        begin
            if (pending_reg == PW'(0))
            begin
                if (b[7] == 1'b0)
                begin
                    cp      = CPW'(b);
                    have_cp = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    pending_next = PW'(1);
                    acc_next     = CPW'(b[4:0]);
                end
                else if (b[7:4] == 4'b1110)
                begin
                    pending_next = PW'(2);
                    acc_next     = CPW'(b[3:0]);
                end
                else
                begin
                    pending_next = PW'(3);
                    acc_next     = CPW'(b[2:0]);
                end
            end
            else
            begin
                pending_next = pend_dec;
                if (pend_dec == PW'(0))
                begin
                    cp       = acc_shift;
                    have_cp  = 1'b1;
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_shift;
                end
            end
        end
    end

    // Fit test against the clamped slot size
    always_comb
    begin
        if (CW'(slot_bytes_reg) > CW'(MAX_SLOT_BYTES))
            size_c = CW'(MAX_SLOT_BYTES);
        else
            size_c = CW'(slot_bytes_reg);
    end

    assign used     = CW'({units_reg, 1'b0});
    assign fits_one = (used + CW'(4)) <= size_c;
    assign fits_two = (used + CW'(6)) <= size_c;
    assign is_pair  = (cp > CPW'(16'hffff));
    assign supp_v   = cp - u8u16sw_pkg::SUPP_OFFSET;
    assign units_p1 = {1'b0, units_reg} + (UW+1)'(1);
    assign units_p2 = {1'b0, units_reg} + (UW+1)'(2);
    assign addr0    = unit_addr(slot_base_reg, {1'b0, units_reg});
    assign addr1    = unit_addr(slot_base_reg, units_p1);
    assign addr2    = unit_addr(slot_base_reg, units_p2);

    // Build the results for this byte
    always_comb
    begin
        logic [UW:0] units_after;
        logic [u8u16sw_pkg::BYTE_ADDR_W-1:0] term_addr;
        units_after = {1'b0, units_reg};
        term_addr   = addr0;
        full_next   = full_reg;
        n_new       = NW'(0);
        for (int i = 0; i < int'(u8u16sw_pkg::RESULT_SLOTS); i++)
        begin
            res_new[i] = '0;
        end
        if (have_cp)
        begin
            if (!is_pair)
            begin
                if (fits_one)
                begin
                    res_new[0].code_unit    = cp[u8u16sw_pkg::CODE_UNIT_W-1:0];
                    res_new[0].byte_address = addr0;
                    n_new       = NW'(1);
                    units_after = units_p1;
                    term_addr   = addr1;
                end
                else
                begin
                    full_next = 1'b1;
                end
            end
            else
            begin
                if (fits_two)
                begin
                    res_new[0].code_unit    = u8u16sw_pkg::HIGH_SURR_BASE
                                              + u8u16sw_pkg::CODE_UNIT_W'(supp_v[CPW-1:10]);
                    res_new[0].byte_address = addr0;
                    res_new[1].code_unit    = u8u16sw_pkg::LOW_SURR_BASE
                                              + u8u16sw_pkg::CODE_UNIT_W'(supp_v[9:0]);
                    res_new[1].byte_address = addr1;
                    n_new       = NW'(2);
                    units_after = units_p2;
                    term_addr   = addr2;
                end
                else
                begin
                    full_next = 1'b1;
                end
            end
        end
        units_next = units_after[UW-1:0];
        // Close the string: append the terminator and clear the state
        if (text_in.end_of_string)
        begin
            res_new[n_new].code_unit     = '0;
            res_new[n_new].byte_address  = term_addr;
            res_new[n_new].is_terminator = 1'b1;
            n_new      = n_new + NW'(1);
            units_next = '0;
            full_next  = 1'b0;
        end
        // Flag the final result of the run
        if (n_new != NW'(0))
        begin
            res_new[n_new - NW'(1)].last_of_run = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_base_reg  <= u8u16sw_pkg::SLOT_BASE_RESET;
            slot_bytes_reg <= u8u16sw_pkg::SLOT_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                u8u16sw_pkg::REG_SLOT_BASE:  slot_base_reg  <= cfg_data;
                u8u16sw_pkg::REG_SLOT_BYTES: slot_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance decode state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            acc_reg     <= '0;
            units_reg   <= '0;
            full_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            if (text_in.end_of_string)
            begin
                pending_reg <= '0;
                acc_reg     <= '0;
            end
            else
            begin
                pending_reg <= pending_next;
                acc_reg     <= acc_next;
            end
            units_reg <= units_next;
            full_reg  <= full_next;
        end
    end

    // Result buffer count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (in_fire)
            cnt_reg <= n_new;
        else if (out_fire)
            cnt_reg <= cnt_reg - NW'(1);
    end

    // Result buffer payload: load on accept, shift down on each transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < int'(u8u16sw_pkg::RESULT_SLOTS); i++)
            begin
                res_reg[i] <= res_new[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < int'(u8u16sw_pkg::RESULT_SLOTS) - 1; i++)
            begin
                res_reg[i] <= res_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire
